/* hdl/tcst_pkg.sv */
// constants shared by the tcp connection state tracker
`default_nettype none

package tcst_pkg;

   // connection state codes
   localparam logic [2:0] ST_CLOSED   = 3'd0;
   localparam logic [2:0] ST_LISTEN   = 3'd1;
   localparam logic [2:0] ST_SYN_SENT = 3'd2;
   localparam logic [2:0] ST_SYN_RECV = 3'd3;
   localparam logic [2:0] ST_ESTAB    = 3'd4;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_SEGMENT      = 2'd0;
   localparam logic [1:0] OP_ACTIVE_OPEN  = 2'd1;
   localparam logic [1:0] OP_PASSIVE_OPEN = 2'd2;

   // segment flag bits
   localparam logic [5:0] FL_NONE = 6'h00;
   localparam logic [5:0] FL_FIN  = 6'h01;
   localparam logic [5:0] FL_SYN  = 6'h02;
   localparam logic [5:0] FL_PSH  = 6'h08;
   localparam logic [5:0] FL_ACK  = 6'h10;

   // control register indexes
   localparam logic [1:0] CSR_ACTIVE_ISN  = 2'd0;
   localparam logic [1:0] CSR_PASSIVE_ISN = 2'd1;
   localparam logic [1:0] CSR_RX_WINDOW   = 2'd2;

   // control register reset values
   localparam logic [31:0] ACTIVE_ISN_RST  = 32'd234893;
   localparam logic [31:0] PASSIVE_ISN_RST = 32'd4747;
   localparam logic [15:0] RX_WINDOW_RST   = 16'd512;

   // stream payload widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 112;

endpackage : tcst_pkg

`default_nettype wire

/* hdl/tcp_connection_state_tracker.sv */
// top level of the tcp connection state tracker
`default_nettype none

// Tracks one tcp connection. Each request transaction is either an open command
// (active or passive, chosen by req_tuser) or the header of an arriving segment;
// each one gives exactly one response transaction with the reply segment to send
// (if any), the connection state after the item and the payload accepted. A
// request is taken into an input register, the state machine and its sequence
// and acknowledgement numbers are updated from that register, and the result
// lands in an output register. One transaction is accepted every clock cycle
// when the response side keeps up; the response is valid once the item has
// passed the input register and the output register. The rate is set by the
// state update loop (a 32-bit three-input add and a 32-bit compare). Control
// registers are written through the csr_ port and must only change while no
// transaction is in flight.
module tcp_connection_state_tracker
   import tcst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: tcp_flags[5:0], seg_seq[37:6], seg_ack[69:38], payload_length[85:70], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: operation[1:0]
   input  wire logic [1:0]            req_tuser,
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: send_valid[0], send_flags[6:1], send_seq[38:7], send_ack[70:39],
   // send_window[86:71], conn_state[89:87], deliver_payload[90],
   // accepted_length[106:91], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // control register write port
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [31:0]           csr_wdata
);

   // control registers
   logic [31:0] act_isn_ff;
   logic [31:0] pas_isn_ff;
   logic [15:0] rx_win_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic [5:0]  in_flags_ff;
   logic [31:0] in_seq_ff;
   logic [31:0] in_ack_ff;
   logic [15:0] in_len_ff;

   // connection state
   logic [2:0]  state_ff, state_in;
   logic [31:0] snd_seq_ff, snd_seq_in;
   logic [31:0] rcv_ack_ff, rcv_ack_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        send_valid_ff, send_valid_in;
   logic [5:0]  send_flags_ff, send_flags_in;
   logic        deliver_ff, deliver_in;
   logic [15:0] acc_len_ff, acc_len_in;
   logic [31:0] send_seq_ff;
   logic [31:0] send_ack_ff;
   logic [15:0] send_win_ff;

   // handshake and pipeline advance
   logic        advance;
   logic        req_fire;
   logic [2:0]  cur_state;
   logic        has_ack;
   logic [31:0] seq_plus_one;
   logic [31:0] seq_len_one;

   // the processing stage moves whenever the result register is free or draining
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, acc_len_ff, deliver_ff, state_ff, send_win_ff,
                        send_ack_ff, send_seq_ff, send_flags_ff, send_valid_ff};

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         act_isn_ff <= ACTIVE_ISN_RST;
         pas_isn_ff <= PASSIVE_ISN_RST;
         rx_win_ff  <= RX_WINDOW_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ACTIVE_ISN:  act_isn_ff <= csr_wdata;
            CSR_PASSIVE_ISN: pas_isn_ff <= csr_wdata;
            CSR_RX_WINDOW:   rx_win_ff  <= csr_wdata[15:0];
            default:         ;
         endcase
      end
   end

   // input register: holds the item until the processing stage takes it
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff    <= req_tuser;
         in_flags_ff <= req_tdata[5:0];
         in_seq_ff   <= req_tdata[37:6];
         in_ack_ff   <= req_tdata[69:38];
         in_len_ff   <= req_tdata[85:70];
      end
   end

   // connection state machine, evaluated on the registered item
   assign cur_state    = (state_ff > ST_ESTAB) ? ST_CLOSED : state_ff;
   assign has_ack      = |(in_flags_ff & FL_ACK);
   assign seq_plus_one = in_seq_ff + 32'd1;
   assign seq_len_one  = in_seq_ff + {16'd0, in_len_ff} + 32'd1;

   always_comb begin
      state_in      = cur_state;
      snd_seq_in    = snd_seq_ff;
      rcv_ack_in    = rcv_ack_ff;
      send_valid_in = 1'b0;
      send_flags_in = FL_NONE;
      deliver_in    = 1'b0;
      acc_len_in    = 16'd0;
      case (in_op_ff)
         OP_ACTIVE_OPEN: begin
            state_in      = ST_SYN_SENT;
            snd_seq_in    = act_isn_ff;
            rcv_ack_in    = 32'd0;
            send_valid_in = 1'b1;
            send_flags_in = FL_SYN;
         end
         OP_PASSIVE_OPEN: begin
            if (cur_state == ST_CLOSED || cur_state == ST_LISTEN) begin
               state_in = ST_LISTEN;
            end
         end
         OP_SEGMENT: begin
            case (cur_state)
               ST_LISTEN: begin
                  // only a bare syn opens the connection
                  if (in_flags_ff == FL_SYN) begin
                     state_in      = ST_SYN_RECV;
                     snd_seq_in    = pas_isn_ff;
                     rcv_ack_in    = seq_plus_one;
                     send_valid_in = 1'b1;
                     send_flags_in = FL_SYN | FL_ACK;
                  end
               end
               ST_SYN_RECV: begin
                  if (has_ack && in_ack_ff == snd_seq_ff + 32'd1) begin
                     state_in   = ST_ESTAB;
                     snd_seq_in = in_ack_ff;
                  end
               end
               ST_SYN_SENT: begin
                  if (has_ack && |(in_flags_ff & FL_SYN)) begin
                     state_in      = ST_ESTAB;
                     rcv_ack_in    = seq_len_one;
                     snd_seq_in    = in_ack_ff;
                     send_valid_in = 1'b1;
                     send_flags_in = FL_ACK;
                  end
               end
               ST_ESTAB: begin
                  if (in_flags_ff == (FL_FIN | FL_ACK)) begin
                     // peer closes: answer fin+ack and drop to closed
                     state_in      = ST_CLOSED;
                     rcv_ack_in    = seq_len_one;
                     snd_seq_in    = in_ack_ff;
                     send_valid_in = 1'b1;
                     send_flags_in = FL_FIN | FL_ACK;
                  end else begin
                     if (has_ack) begin
                        snd_seq_in = in_ack_ff;
                        rcv_ack_in = rcv_ack_ff + {16'd0, in_len_ff};
                     end
                     if (has_ack && |(in_flags_ff & FL_PSH)) begin
                        deliver_in    = 1'b1;
                        send_valid_in = 1'b1;
                        send_flags_in = FL_ACK;
                     end
                     acc_len_in = in_len_ff;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // state and result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLOSED;
         snd_seq_ff   <= 32'd0;
         rcv_ack_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance && in_valid_ff) begin
            state_ff   <= state_in;
            snd_seq_ff <= snd_seq_in;
            rcv_ack_ff <= rcv_ack_in;
         end
      end
   end

   // result payload; reply numbers are the updated ones, zero when no reply
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         send_valid_ff <= send_valid_in;
         send_flags_ff <= send_flags_in;
         send_seq_ff   <= send_valid_in ? snd_seq_in : 32'd0;
         send_ack_ff   <= send_valid_in ? rcv_ack_in : 32'd0;
         send_win_ff   <= send_valid_in ? rx_win_ff : 16'd0;
         deliver_ff    <= deliver_in;
         acc_len_ff    <= acc_len_in;
      end
   end

`ifndef NO_ASSERTIONS
   // the stored state never leaves the defined codes
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_ESTAB)
      else $error("state register holds an undefined code");

   // a response without a reply carries zero reply fields
   a_no_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !send_valid_ff) |->
         (send_flags_ff == FL_NONE && send_seq_ff == 32'd0 &&
          send_ack_ff == 32'd0 && send_win_ff == 16'd0))
      else $error("reply fields set on a response without a reply");

   // payload delivery comes with an ack reply in the established state
   a_deliver_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && deliver_ff) |->
         (send_valid_ff && send_flags_ff == FL_ACK && state_ff == ST_ESTAB))
      else $error("payload delivered without ack in established state");

   // accepted length only reported while established
   a_len_estab: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && acc_len_ff != 16'd0) |-> state_ff == ST_ESTAB)
      else $error("accepted length outside established state");

   // a held response keeps the connection state frozen
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(state_ff))
      else $error("state changed while the response was stalled");
`endif

endmodule : tcp_connection_state_tracker

`default_nettype wire
